/* rtl/multi_source_button_debouncer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-source button debouncer.
// Each macro builds one labeled concurrent assertion on the rising clock edge,
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef MULTI_SOURCE_BUTTON_DEBOUNCER_ASSERT_SVH
`define MULTI_SOURCE_BUTTON_DEBOUNCER_ASSERT_SVH

// Same-cycle implication: when the condition holds, the check must hold too.
`define MSBD_ASSERT_NOW(label, clk, rstn, cond, check) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (check)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication: when the condition holds, the check holds in the next cycle.
`define MSBD_ASSERT_NEXT(label, clk, rstn, cond, check) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (check)) \
        else $error("assertion failed: next-cycle check");

`endif

/* rtl/msbd_pkg.sv */
// ----------------------------------------------------------------------------
// msbd_pkg
// Shared types, constants and register indexes of the button debouncer.
// ----------------------------------------------------------------------------
package msbd_pkg;

    // Default sizes of the design.
    localparam int NUM_BUTTONS_DEF = 9;
    localparam int COUNT_WIDTH_DEF = 8;

    // Fixed field widths.
    localparam int BUTTON_W = 9;
    localparam int SERIAL_W = 8;
    localparam int KEY_W    = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd5;
    localparam logic [CFG_W-1:0] INCREMENT_RST = 8'd1;
    localparam logic [CFG_W-1:0] HOLD_TIME_RST = 8'd10;

    // One input request: a task tick for all buttons.
    typedef struct packed {
        logic [BUTTON_W-1:0] wired_levels;
        logic [SERIAL_W-1:0] serial_levels;
        logic                remote_valid;
        logic [KEY_W-1:0]    remote_key;
        logic                remote_repeat;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [BUTTON_W-1:0] pressed_bits;
        logic [BUTTON_W-1:0] pressed_once_bits;
        logic [BUTTON_W-1:0] remote_pressed_bits;
    } out_item_t;

    // Configuration seen by every lane.
    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] increment;
        logic [CFG_W-1:0] hold_time;
    } cfg_t;

    // Per-lane controls derived from the input request.
    typedef struct packed {
        logic held;
        logic serial;
        logic valid;
        logic hit;
        logic rep;
    } lane_in_t;

    // Per-lane flags after the update, handed to the merge stage.
    typedef struct packed {
        logic pressed;
        logic once;
        logic rpressed;
    } lane_flags_t;

endpackage

/* rtl/msbd_lane.sv */
// ----------------------------------------------------------------------------
// msbd_lane
// State and update of one button: wired hold counter and remote hold timer.
// ----------------------------------------------------------------------------
module msbd_lane
    import msbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  cfg_t        cfg,
    input  lane_in_t    ctrl,
    output lane_flags_t flags
);

    localparam int SUM_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
    localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_WIDTH{1'b1}});

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   wpressed_reg, wpressed_next;
    logic                   wonce_reg, wonce_next;
    logic [CFG_W-1:0]       timer_reg, timer_next;
    logic                   rpressed_reg, rpressed_next;
    logic                   ronce_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] count_ext;
    logic [SUM_W-1:0] thr_ext;

    // Wired source: saturating counter, then threshold qualification.
    always_comb begin
        sum = SUM_W'(count_reg) + SUM_W'(cfg.increment);
        if (ctrl.held) begin
            count_next = (sum < COUNT_MAX) ? sum[COUNT_WIDTH-1:0] : count_reg;
        end else begin
            count_next = '0;
        end
        count_ext = SUM_W'(count_next);
        thr_ext   = SUM_W'(cfg.threshold);
        wpressed_next = wpressed_reg;
        wonce_next    = wonce_reg;
        if (count_ext > thr_ext) begin
            wpressed_next = 1'b1;
            wonce_next    = 1'b0;
        end else if (count_ext == thr_ext) begin
            wonce_next = 1'b1;
        end else begin
            wpressed_next = 1'b0;
            wonce_next    = 1'b0;
        end
    end

    // Remote source: press on a matching frame, hold timer on idle ticks.
    // The remote one-shot lasts a single tick, so it needs no register.
    always_comb begin
        timer_next    = timer_reg;
        rpressed_next = rpressed_reg;
        ronce_next    = 1'b0;
        if (ctrl.valid) begin
            if (ctrl.hit) begin
                ronce_next    = !rpressed_reg && !ctrl.rep;
                rpressed_next = 1'b1;
                timer_next    = cfg.hold_time;
            end else begin
                rpressed_next = 1'b0;
            end
        end else if (timer_reg > cfg.increment) begin
            timer_next = timer_reg - cfg.increment;
        end else begin
            timer_next    = cfg.hold_time;
            rpressed_next = 1'b0;
        end
    end

    // Flags of this tick, combined with the serial bit.
    assign flags.pressed  = wpressed_next | ctrl.serial | rpressed_next;
    assign flags.once     = wonce_next | ctrl.serial | ronce_next;
    assign flags.rpressed = rpressed_next;

    // Lane state advances once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            wpressed_reg <= 1'b0;
            wonce_reg    <= 1'b0;
            timer_reg    <= '0;
            rpressed_reg <= 1'b0;
        end else if (accept) begin
            count_reg    <= count_next;
            wpressed_reg <= wpressed_next;
            wonce_reg    <= wonce_next;
            timer_reg    <= timer_next;
            rpressed_reg <= rpressed_next;
        end
    end

endmodule

/* rtl/msbd_merge.sv */
// ----------------------------------------------------------------------------
// msbd_merge
// Gathers the lane flags into one result and holds it in a two-entry
// output buffer (main register plus skid register).
// ----------------------------------------------------------------------------
module msbd_merge
    import msbd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    output logic                         push_ready,
    input  lane_flags_t [NUM_BUTTONS-1:0] flags,
    output logic                         m_valid,
    input  logic                         m_ready,
    output out_item_t                    m_item
);

    out_item_t result;
    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      pop;

    // Buttons beyond the field width are dropped from the result.
    for (genvar b = 0; b < BUTTON_W; b++) begin : g_bit
        if (b < NUM_BUTTONS) begin : g_used
            assign result.pressed_bits[b]        = flags[b].pressed;
            assign result.pressed_once_bits[b]   = flags[b].once;
            assign result.remote_pressed_bits[b] = flags[b].rpressed;
        end else begin : g_unused
            assign result.pressed_bits[b]        = 1'b0;
            assign result.pressed_once_bits[b]   = 1'b0;
            assign result.remote_pressed_bits[b] = 1'b0;
        end
    end

    assign pop        = main_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_item     = main_reg;

    // Drain first, then place the new result where the order is kept.
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!main_valid_next) begin
                main_next       = result;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Valid flags are reset; the data registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/multi_source_button_debouncer.sv */
// ----------------------------------------------------------------------------
// multi_source_button_debouncer
// Debounces wired buttons and merges them with serial and remote sources.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Carries
//  input     s_valid s_ready s_item             one tick of raw levels and key
//  result    m_valid m_ready m_item             merged pressed and one-shot bits
//  config    cfg_valid cfg_ready cfg_index/data register write, always ready
//
// One request is accepted per cycle while s_ready is high; its result is
// written into the output buffer when the request is accepted. The lane
// update is combinational and runs for all lanes in parallel.
// A two-entry output buffer lets two results wait while the result channel
// stalls; input ready drops only when both entries are full.
// Reset is synchronous and clears lane state, config and buffer valid flags.
// ----------------------------------------------------------------------------
module multi_source_button_debouncer
    import msbd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        accept;
    lane_in_t    [NUM_BUTTONS-1:0] ctrl;
    lane_flags_t [NUM_BUTTONS-1:0] flags;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Configuration register writes; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_THRESHOLD: cfg_next.threshold = cfg_data;
                REG_INCREMENT: cfg_next.increment = cfg_data;
                REG_HOLD_TIME: cfg_next.hold_time = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.increment <= INCREMENT_RST;
            cfg_reg.hold_time <= HOLD_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // One lane per button, each fed from its own bits of the request.
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        if (b < BUTTON_W) begin : g_wired
            assign ctrl[b].held = s_item.wired_levels[b];
        end else begin : g_no_wired
            assign ctrl[b].held = 1'b0;
        end
        if (b < SERIAL_W) begin : g_serial
            assign ctrl[b].serial = s_item.serial_levels[b];
        end else begin : g_no_serial
            assign ctrl[b].serial = 1'b0;
        end
        assign ctrl[b].valid = s_item.remote_valid;
        assign ctrl[b].hit   = (s_item.remote_key == KEY_W'(b));
        assign ctrl[b].rep   = s_item.remote_repeat;

        msbd_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (accept),
            .cfg     (cfg_reg),
            .ctrl    (ctrl[b]),
            .flags   (flags[b])
        );
    end

    // Merge the lanes and buffer the result.
    msbd_merge #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_ready (s_ready),
        .flags      (flags),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

/* rtl/msbd_checker.sv */
// ----------------------------------------------------------------------------
// msbd_checker
// Port-level checks of the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_source_button_debouncer_assert.svh"

module msbd_checker
    import msbd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // Remote presses that are missing from the merged pressed bits.
    logic [BUTTON_W-1:0] remote_only;

    assign remote_only = m_item.remote_pressed_bits & ~m_item.pressed_bits;

    // A stalled result keeps its value.
    `MSBD_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // An accepted request always leaves a result waiting in the next cycle.
    `MSBD_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)

    // Input back-pressure only happens while results are waiting.
    `MSBD_ASSERT_NOW(a_ready_low_needs_result, aclk, aresetn, !s_ready, m_valid)

    // A remote press is always part of the merged pressed bits.
    `MSBD_ASSERT_NOW(a_remote_in_merged, aclk, aresetn, m_valid, remote_only == '0)

endmodule

bind multi_source_button_debouncer msbd_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

/* bench/multi_source_button_debouncer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_source_button_debouncer_test
// Self-checking bench for the multi-source button debouncer. Ticks of wired,
// serial and remote button data are driven through the valid/ready input
// channel. A scoreboard class mirrors the lane state, predicts the merged
// press bits for each accepted tick and compares them with the result
// channel. The run steps through several register settings, including their
// extremes, and stalls both channels at random.
// ----------------------------------------------------------------------------
module multi_source_button_debouncer_test;
    import msbd_pkg::*;

    localparam int COUNT_LIMIT = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_TICKS = 160;

    // Mirror of the debouncer lanes plus the queue of predicted results.
    class tick_scoreboard;
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] increment;
        logic [CFG_W-1:0] hold_time;
        logic [COUNT_WIDTH_DEF-1:0] hold_cnt [BUTTON_W];
        bit                        wired_prs [BUTTON_W];
        bit                        wired_one [BUTTON_W];
        logic [7:0]                remote_tmr [BUTTON_W];
        bit                        remote_prs [BUTTON_W];
        bit                        remote_one [BUTTON_W];
        out_item_t                 pending [$];
        int                        errors;
        int                        ticks_noted;
        int                        results_checked;
        int                        remote_frames;

        function void clear_state();
            threshold = THRESHOLD_RST;
            increment = INCREMENT_RST;
            hold_time = HOLD_TIME_RST;
            for (int b = 0; b < BUTTON_W; b++) begin
                hold_cnt[b]   = '0;
                wired_prs[b]  = 1'b0;
                wired_one[b]  = 1'b0;
                remote_tmr[b] = '0;
                remote_prs[b] = 1'b0;
                remote_one[b] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_THRESHOLD: threshold = val;
                REG_INCREMENT: increment = val;
                REG_HOLD_TIME: hold_time = val;
                default: ;
            endcase
        endfunction

        // Advance every lane by one tick and queue the merged flags.
        function void note_tick(in_item_t it);
            out_item_t predicted;
            bit        held;
            bit        ser;
            predicted = '0;
            if (it.remote_valid)
                remote_frames++;
            for (int b = 0; b < BUTTON_W; b++) begin
                held = it.wired_levels[b];
                ser  = (b < SERIAL_W) && it.serial_levels[b];

                // Wired lane: saturating counter, qualified against the threshold.
                if (held) begin
                    if (int'(hold_cnt[b]) + int'(increment) < COUNT_LIMIT)
                        hold_cnt[b] = hold_cnt[b] + increment;
                end else begin
                    hold_cnt[b] = '0;
                end
                if (hold_cnt[b] > threshold) begin
                    wired_prs[b] = 1'b1;
                    wired_one[b] = 1'b0;
                end else if (hold_cnt[b] == threshold) begin
                    wired_one[b] = 1'b1;
                end else begin
                    wired_prs[b] = 1'b0;
                    wired_one[b] = 1'b0;
                end

                // Remote lane: frames press one key, the timer releases it.
                if (it.remote_valid) begin
                    if (it.remote_key == b) begin
                        remote_one[b] = !remote_prs[b] && !it.remote_repeat;
                        remote_prs[b] = 1'b1;
                        remote_tmr[b] = hold_time;
                    end else begin
                        remote_prs[b] = 1'b0;
                        remote_one[b] = 1'b0;
                    end
                end else begin
                    if (remote_tmr[b] > increment) begin
                        remote_tmr[b] = remote_tmr[b] - increment;
                    end else begin
                        remote_tmr[b] = hold_time;
                        remote_prs[b] = 1'b0;
                    end
                    remote_one[b] = 1'b0;
                end

                predicted.pressed_bits[b]        = wired_prs[b] || ser || remote_prs[b];
                predicted.pressed_once_bits[b]   = wired_one[b] || ser || remote_one[b];
                predicted.remote_pressed_bits[b] = remote_prs[b];
            end
            ticks_noted++;
            pending.push_back(predicted);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            results_checked++;
            if (got.pressed_bits !== want.pressed_bits) begin
                $display("%0t ns: pressed_bits expected %h actual %h",
                         $time, want.pressed_bits, got.pressed_bits);
                errors++;
            end
            if (got.pressed_once_bits !== want.pressed_once_bits) begin
                $display("%0t ns: pressed_once_bits expected %h actual %h",
                         $time, want.pressed_once_bits, got.pressed_once_bits);
                errors++;
            end
            if (got.remote_pressed_bits !== want.remote_pressed_bits) begin
                $display("%0t ns: remote_pressed_bits expected %h actual %h",
                         $time, want.remote_pressed_bits, got.remote_pressed_bits);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tick_scoreboard sb;
    bit             tx_idle_on;
    bit             rx_idle_on;
    int             rx_holdoff_cycles;
    int             settings_used;

    // Stimulus shaping state: buttons held down, remote activity.
    logic [BUTTON_W-1:0] held_mask;
    logic [KEY_W-1:0]    last_key;
    int                  remote_quiet;

    multi_source_button_debouncer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Gap length: mostly short, a few long.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_item_t mk_tick(logic [BUTTON_W-1:0] wired, logic [SERIAL_W-1:0] serial,
                                         logic valid, logic [KEY_W-1:0] key, logic rep);
        in_item_t it;
        it.wired_levels  = wired;
        it.serial_levels = serial;
        it.remote_valid  = valid;
        it.remote_key    = key;
        it.remote_repeat = rep;
        return it;
    endfunction

    // Mostly realistic ticks: buttons held for long stretches, key frames
    // followed by repeats, quiet periods; a tenth are pure noise.
    function automatic in_item_t next_random_tick();
        in_item_t it;
        if ($urandom_range(0, 99) < 10) begin
            it = mk_tick(BUTTON_W'($urandom), SERIAL_W'($urandom), 1'($urandom),
                         KEY_W'($urandom), 1'($urandom));
            return it;
        end
        if ($urandom_range(0, 99) < 4)
            held_mask[$urandom_range(0, BUTTON_W - 1)] ^= 1'b1;
        if ($urandom_range(0, 199) == 0)
            held_mask = BUTTON_W'($urandom);
        it.wired_levels = held_mask;
        // A short bounce on one button.
        if ($urandom_range(0, 99) < 2)
            it.wired_levels[$urandom_range(0, BUTTON_W - 1)] ^= 1'b1;
        it.serial_levels = ($urandom_range(0, 99) < 85) ? '0 : SERIAL_W'($urandom);
        if (remote_quiet > 0) begin
            remote_quiet--;
            it.remote_valid = 1'b0;
        end else begin
            it.remote_valid = ($urandom_range(0, 99) < 35);
            if ($urandom_range(0, 99) < 3)
                remote_quiet = $urandom_range(5, 300);
        end
        it.remote_repeat = 1'($urandom);
        it.remote_key    = KEY_W'($urandom);
        if (it.remote_valid) begin
            if ($urandom_range(0, 99) < 70) begin
                it.remote_key    = last_key;
                it.remote_repeat = ($urandom_range(0, 9) != 0);
            end else begin
                if ($urandom_range(0, 99) < 85)
                    it.remote_key = KEY_W'($urandom_range(0, BUTTON_W - 1));
                else
                    it.remote_key = KEY_W'($urandom_range(BUTTON_W, 15));
                it.remote_repeat = ($urandom_range(0, 7) == 0);
                last_key         = it.remote_key;
            end
        end
        return it;
    endfunction

    // Offer one tick, wait for acceptance, then at times idle for a random gap.
    task automatic send_tick(in_item_t it);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(it);
        if (tx_idle_on && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Let every predicted result come back, then a few more cycles.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apply_setting(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] inc,
                                 logic [CFG_W-1:0] hold);
        wait_drained();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_INCREMENT, inc);
        write_reg(REG_HOLD_TIME, hold);
        settings_used++;
    endtask

    // Result side: random ready gaps, plus a long hold-off on request.
    initial begin
        int gap_left;
        gap_left = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_holdoff_cycles > 0) begin
                m_ready <= 1'b0;
                rx_holdoff_cycles--;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 25)
                    gap_left = pick_gap();
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_item);
        end
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("multi_source_button_debouncer verification failed");
        $finish;
    end

    // Main sequence: reset, directed ticks, then randomized phases.
    initial begin
        logic [CFG_W-1:0] thr_list  [6];
        logic [CFG_W-1:0] inc_list  [6];
        logic [CFG_W-1:0] hold_list [6];
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] inc;
        logic [CFG_W-1:0] hold;

        thr_list  = '{8'd5, 8'd0, 8'd254, 8'd254, 8'd0, 8'd255};
        inc_list  = '{8'd1, 8'd1, 8'd254, 8'd1, 8'd0, 8'd3};
        hold_list = '{8'd10, 8'd1, 8'd255, 8'd255, 8'd1, 8'd7};

        sb = new();
        sb.clear_state();
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_item            = '0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_THRESHOLD;
        cfg_data          = '0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        rx_holdoff_cycles = 0;
        settings_used     = 1;
        held_mask         = '0;
        last_key          = '0;
        remote_quiet      = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: idle tick, all buttons held through the threshold with a
        // full serial byte, remote presses and repeats, a key without button,
        // then invalid ticks until the hold timer releases the remote key.
        send_tick(mk_tick('0, '0, 1'b0, '0, 1'b0));
        send_tick(mk_tick('1, '1, 1'b0, '0, 1'b0));
        repeat (6) send_tick(mk_tick('1, '0, 1'b0, '0, 1'b0));
        send_tick(mk_tick('1, '0, 1'b1, 4'd0, 1'b0));
        send_tick(mk_tick('1, '0, 1'b1, 4'd0, 1'b1));
        send_tick(mk_tick('0, '0, 1'b1, 4'd8, 1'b0));
        send_tick(mk_tick('0, '0, 1'b1, 4'd15, 1'b0));
        send_tick(mk_tick('0, '0, 1'b1, 4'd9, 1'b1));
        send_tick(mk_tick('0, '0, 1'b1, 4'd3, 1'b1));
        send_tick(mk_tick('0, '0, 1'b1, 4'd3, 1'b0));
        repeat (10) send_tick(mk_tick('0, '0, 1'b0, 4'd15, 1'b1));

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 6) begin
                thr  = thr_list[p];
                inc  = inc_list[p];
                hold = hold_list[p];
            end else begin
                thr = CFG_W'($urandom_range(0, 254));
                if ($urandom_range(0, 3) == 0)
                    inc = CFG_W'($urandom_range(1, 254));
                else
                    inc = CFG_W'($urandom_range(1, 8));
                hold = CFG_W'($urandom_range(1, 255));
            end
            apply_setting(thr, inc, hold);
            tx_idle_on = !(p == 1 || p % 4 == 3);
            rx_idle_on = (p % 4 != 3);
            // Back up the result channel so the input side has to stall.
            if (p == 1)
                rx_holdoff_cycles = 300;
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(next_random_tick());
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Covered %0d ticks under %0d register settings, %0d remote frames;",
                 sb.ticks_noted, settings_used, sb.remote_frames);
        $display("%0d results compared, with random stalls and one long result hold-off.",
                 sb.results_checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("multi_source_button_debouncer verification clean");
        end else begin
            $display("multi_source_button_debouncer verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/msbd_pkg.sv
rtl/msbd_lane.sv
rtl/msbd_merge.sv
rtl/multi_source_button_debouncer.sv
rtl/msbd_checker.sv
bench/multi_source_button_debouncer_test.sv
